>>> rtl/eihc_pkg.sv
package eihc_pkg;

  // Frame length limit and counter width
  localparam int unsigned MAX_FRAME_BYTES = 65536;
  localparam int unsigned POS_W           = 17;

  // Fixed header offsets (bytes from frame start)
  localparam logic [POS_W-1:0] OFS_ETYPE_HI = POS_W'(12);
  localparam logic [POS_W-1:0] OFS_ETYPE_LO = POS_W'(13);
  localparam logic [POS_W-1:0] OFS_VER_IHL  = POS_W'(14);
  localparam logic [POS_W-1:0] OFS_TTL      = POS_W'(22);
  localparam logic [POS_W-1:0] OFS_PROTO    = POS_W'(23);
  localparam logic [POS_W-1:0] OFS_SRC_LO   = POS_W'(26);
  localparam logic [POS_W-1:0] OFS_SRC_HI   = POS_W'(29);
  localparam logic [POS_W-1:0] OFS_DST_LO   = POS_W'(30);
  localparam logic [POS_W-1:0] OFS_DST_HI   = POS_W'(33);
  localparam logic [POS_W-1:0] ETH_HDR_LEN  = POS_W'(14);
  localparam logic [POS_W-1:0] MAX_LEN      = POS_W'(MAX_FRAME_BYTES);

  // Length minimums
  localparam logic [POS_W-1:0] IP_MIN_HDR   = POS_W'(20);
  localparam logic [POS_W-1:0] TCP_MIN_HDR  = POS_W'(20);
  localparam logic [POS_W-1:0] UDP_MIN_HDR  = POS_W'(8);
  localparam logic [3:0]       IP_VERSION4  = 4'd4;

  // EtherTypes and IP protocols
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // Frame class codes
  localparam logic [2:0] CLS_REJECT  = 3'd0;
  localparam logic [2:0] CLS_TCP     = 3'd1;
  localparam logic [2:0] CLS_UDP     = 3'd2;
  localparam logic [2:0] CLS_ICMP    = 3'd3;
  localparam logic [2:0] CLS_IPV4    = 3'd4;
  localparam logic [2:0] CLS_ARP     = 3'd5;
  localparam logic [2:0] CLS_IPV6    = 3'd6;
  localparam logic [2:0] CLS_OTHER   = 3'd7;

  // Result item, first field in the highest bits
  typedef struct packed {
    logic [POS_W-1:0] frame_length;
    logic [15:0]      destination_port;
    logic [15:0]      source_port;
    logic             ports_valid;
    logic [7:0]       time_to_live;
    logic [31:0]      destination_address;
    logic [31:0]      source_address;
    logic             addresses_valid;
    logic             decoded;
    logic [2:0]       frame_class;
    logic             accepted;
  } result_t;

endpackage

>>> rtl/ethernet_ipv4_header_classifier.sv
// Ethernet / IPv4 header classifier.
// Input channel (in_*): one frame byte per item in in_tdata, in_tlast on the
// final byte of a frame. Output channel (out_*): one 128-bit classification
// item per frame, issued for the byte that carries in_tlast.
// Header fields are captured at their byte offsets as bytes stream past; the
// transport offsets follow the captured IHL. The classification is formed in
// the same cycle as the last byte and registered into the result register,
// or into the skid register while the result register waits on out_tready.
// Throughput: one byte per cycle, frames may follow back to back. A result
// register plus one skid register sit on the output; in_tready drops only
// while the skid register is occupied, i.e. after a frame has ended while the
// previous result was still waiting on out_tready.
// Reset (rst_n low, synchronous): byte counter and captured fields clear,
// both output registers empty. Frame length saturates at MAX_FRAME_BYTES;
// bytes past it are neither counted nor captured.
module ethernet_ipv4_header_classifier
  import eihc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] frame_byte
  input  logic         in_tlast,   // frame_end
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] accepted, [3:1] frame_class, [4] decoded, [5] addresses_valid,
  // [37:6] source_address, [69:38] destination_address, [77:70] time_to_live,
  // [78] ports_valid, [94:79] source_port, [110:95] destination_port,
  // [127:111] frame_length
  output logic [127:0] out_tdata
);

  // Frame state
  logic [POS_W-1:0] pos_r, pos_nxt, cap_pos;
  logic [15:0]      etype_r, etype_nxt, cap_etype;
  logic [7:0]       vihl_r, vihl_nxt, cap_vihl;
  logic [7:0]       proto_r, proto_nxt, cap_proto;
  logic [7:0]       ttl_r, ttl_nxt, cap_ttl;
  logic [31:0]      src_r, src_nxt, cap_src;
  logic [31:0]      dst_r, dst_nxt, cap_dst;
  logic [7:0]       tcpofs_r, tcpofs_nxt, cap_tcpofs;
  logic [15:0]      sport_r, sport_nxt, cap_sport;
  logic [15:0]      dport_r, dport_nxt, cap_dport;

  // Output registers
  result_t out_r, skid_r, res;
  logic    out_valid_r, skid_valid_r;

  logic             in_fire, res_fire, out_free;
  logic [5:0]       ip_len_cur;
  logic [POS_W-1:0] tport;
  logic [POS_W-1:0] pay, hl, tl, th;
  logic             ipv4_ok;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign res_fire  = in_fire && in_tlast;
  assign out_free  = !out_valid_r || out_tready;

  assign ip_len_cur = {vihl_r[3:0], 2'b00};
  assign tport      = ETH_HDR_LEN + POS_W'(ip_len_cur);

  // Capture the current byte at its offset
  always_comb begin
    cap_pos    = pos_r;
    cap_etype  = etype_r;
    cap_vihl   = vihl_r;
    cap_proto  = proto_r;
    cap_ttl    = ttl_r;
    cap_src    = src_r;
    cap_dst    = dst_r;
    cap_tcpofs = tcpofs_r;
    cap_sport  = sport_r;
    cap_dport  = dport_r;
    if (pos_r < MAX_LEN) begin
      cap_pos = pos_r + POS_W'(1);
      if (pos_r == OFS_ETYPE_HI) begin
        cap_etype = {in_tdata, etype_r[7:0]};
      end else if (pos_r == OFS_ETYPE_LO) begin
        cap_etype = {etype_r[15:8], in_tdata};
      end else if (pos_r == OFS_VER_IHL) begin
        cap_vihl = in_tdata;
      end else if (pos_r == OFS_TTL) begin
        cap_ttl = in_tdata;
      end else if (pos_r == OFS_PROTO) begin
        cap_proto = in_tdata;
      end else if (pos_r >= OFS_SRC_LO && pos_r <= OFS_SRC_HI) begin
        cap_src = {src_r[23:0], in_tdata};
      end else if (pos_r >= OFS_DST_LO && pos_r <= OFS_DST_HI) begin
        cap_dst = {dst_r[23:0], in_tdata};
      end
      // Transport fields follow the IP header length
      if (pos_r > OFS_VER_IHL && POS_W'(ip_len_cur) >= IP_MIN_HDR) begin
        if (pos_r == tport) begin
          cap_sport = {in_tdata, sport_r[7:0]};
        end else if (pos_r == tport + POS_W'(1)) begin
          cap_sport = {sport_r[15:8], in_tdata};
        end else if (pos_r == tport + POS_W'(2)) begin
          cap_dport = {in_tdata, dport_r[7:0]};
        end else if (pos_r == tport + POS_W'(3)) begin
          cap_dport = {dport_r[15:8], in_tdata};
        end else if (pos_r == tport + POS_W'(12)) begin
          cap_tcpofs = in_tdata;
        end
      end
    end
  end

  // Classify from the captured fields
  assign pay = cap_pos - ETH_HDR_LEN;
  assign hl  = POS_W'({cap_vihl[3:0], 2'b00});
  assign tl  = pay - hl;
  assign th  = POS_W'({cap_tcpofs[7:4], 2'b00});
  assign ipv4_ok = pay >= IP_MIN_HDR && cap_vihl[7:4] == IP_VERSION4 &&
                   hl >= IP_MIN_HDR && hl <= pay;

  always_comb begin
    res              = '0;
    res.frame_length = cap_pos;
    if (cap_pos >= ETH_HDR_LEN) begin
      if (cap_etype == ETYPE_IPV4) begin
        if (ipv4_ok) begin
          res.decoded             = 1'b1;
          res.addresses_valid     = 1'b1;
          res.source_address      = cap_src;
          res.destination_address = cap_dst;
          res.time_to_live        = cap_ttl;
          if (cap_proto == PROTO_TCP) begin
            res.frame_class = CLS_TCP;
            res.ports_valid = tl >= TCP_MIN_HDR && th >= TCP_MIN_HDR && th <= tl;
          end else if (cap_proto == PROTO_UDP) begin
            res.frame_class = CLS_UDP;
            res.ports_valid = tl >= UDP_MIN_HDR;
          end else if (cap_proto == PROTO_ICMP) begin
            res.frame_class = CLS_ICMP;
          end else begin
            res.frame_class = CLS_IPV4;
          end
          if (res.ports_valid) begin
            res.source_port      = cap_sport;
            res.destination_port = cap_dport;
          end
        end else begin
          res.frame_class = CLS_REJECT;
        end
      end else if (cap_etype == ETYPE_ARP) begin
        res.frame_class = CLS_ARP;
        res.decoded     = 1'b1;
      end else if (cap_etype == ETYPE_IPV6) begin
        res.frame_class = CLS_IPV6;
      end else begin
        res.frame_class = CLS_OTHER;
      end
    end
    res.accepted = res.frame_class != CLS_REJECT;
  end

  // Advance frame state; clear it after the last byte
  always_comb begin
    pos_nxt    = pos_r;
    etype_nxt  = etype_r;
    vihl_nxt   = vihl_r;
    proto_nxt  = proto_r;
    ttl_nxt    = ttl_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    tcpofs_nxt = tcpofs_r;
    sport_nxt  = sport_r;
    dport_nxt  = dport_r;
    if (res_fire) begin
      pos_nxt    = '0;
      etype_nxt  = '0;
      vihl_nxt   = '0;
      proto_nxt  = '0;
      ttl_nxt    = '0;
      src_nxt    = '0;
      dst_nxt    = '0;
      tcpofs_nxt = '0;
      sport_nxt  = '0;
      dport_nxt  = '0;
    end else if (in_fire) begin
      pos_nxt    = cap_pos;
      etype_nxt  = cap_etype;
      vihl_nxt   = cap_vihl;
      proto_nxt  = cap_proto;
      ttl_nxt    = cap_ttl;
      src_nxt    = cap_src;
      dst_nxt    = cap_dst;
      tcpofs_nxt = cap_tcpofs;
      sport_nxt  = cap_sport;
      dport_nxt  = cap_dport;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      etype_r  <= '0;
      vihl_r   <= '0;
      proto_r  <= '0;
      ttl_r    <= '0;
      src_r    <= '0;
      dst_r    <= '0;
      tcpofs_r <= '0;
      sport_r  <= '0;
      dport_r  <= '0;
    end else begin
      pos_r    <= pos_nxt;
      etype_r  <= etype_nxt;
      vihl_r   <= vihl_nxt;
      proto_r  <= proto_nxt;
      ttl_r    <= ttl_nxt;
      src_r    <= src_nxt;
      dst_r    <= dst_nxt;
      tcpofs_r <= tcpofs_nxt;
      sport_r  <= sport_nxt;
      dport_r  <= dport_nxt;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (res_fire) begin
        out_r <= res;
      end
    end else if (res_fire) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

>>> verif/ethernet_ipv4_header_classifier_tb.sv
module ethernet_ipv4_header_classifier_tb;
  import eihc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_PRINTED = 30;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'h00;   // [7:0] frame_byte
  logic         in_tlast   = 1'b0;    // frame_end
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [0] accepted, [3:1] frame_class, [4] decoded, [5] addresses_valid,
  // [37:6] source_address, [69:38] destination_address, [77:70] time_to_live,
  // [78] ports_valid, [94:79] source_port, [110:95] destination_port,
  // [127:111] frame_length
  logic [127:0] out_tdata;

  ethernet_ipv4_header_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Header fields captured so far in the current frame
  int unsigned frame_pos  = 0;
  logic [15:0] cap_etype  = '0;
  logic [7:0]  cap_vihl   = '0;
  logic [7:0]  cap_proto  = '0;
  logic [7:0]  cap_ttl    = '0;
  logic [31:0] cap_src    = '0;
  logic [31:0] cap_dst    = '0;
  logic [7:0]  cap_doff   = '0;
  logic [15:0] cap_sport  = '0;
  logic [15:0] cap_dport  = '0;

  result_t     predicted_results[$];
  logic [7:0]  frame_bytes[$];

  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned rx_stall_left = 0;
  int unsigned error_count   = 0;
  int unsigned result_count  = 0;
  int unsigned frames_sent   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned ports_seen    = 0;
  int unsigned class_seen[8];
  int unsigned cycle_count   = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               predicted_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < MAX_PRINTED)
      $display("ERROR result %0d %s: got %0h expected %0h", result_count, what, got, want);
    error_count++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the header capture by one byte; classify on the last byte
  task automatic track_byte(input logic [7:0] b, input logic last);
    result_t     r;
    int unsigned ihl_bytes, tp, pay, hl, tl, th;
    logic [2:0]  cls;
    logic        dec, addr_ok, port_ok;
    if (frame_pos < MAX_FRAME_BYTES) begin
      ihl_bytes = 4 * cap_vihl[3:0];
      if (frame_pos == OFS_ETYPE_HI) cap_etype[15:8] = b;
      else if (frame_pos == OFS_ETYPE_LO) cap_etype[7:0] = b;
      else if (frame_pos == OFS_VER_IHL) cap_vihl = b;
      else if (frame_pos == OFS_TTL) cap_ttl = b;
      else if (frame_pos == OFS_PROTO) cap_proto = b;
      else if (frame_pos >= OFS_SRC_LO && frame_pos <= OFS_SRC_HI)
        cap_src = {cap_src[23:0], b};
      else if (frame_pos >= OFS_DST_LO && frame_pos <= OFS_DST_HI)
        cap_dst = {cap_dst[23:0], b};
      // Transport fields sit after the IPv4 header, wherever IHL puts it
      if (frame_pos > OFS_VER_IHL && ihl_bytes >= IP_MIN_HDR) begin
        tp = ETH_HDR_LEN + ihl_bytes;
        if (frame_pos == tp) cap_sport[15:8] = b;
        else if (frame_pos == tp + 1) cap_sport[7:0] = b;
        else if (frame_pos == tp + 2) cap_dport[15:8] = b;
        else if (frame_pos == tp + 3) cap_dport[7:0] = b;
        else if (frame_pos == tp + 12) cap_doff = b;
      end
      frame_pos++;
    end
    if (last) begin
      cls = CLS_REJECT;
      dec = 1'b0;
      addr_ok = 1'b0;
      port_ok = 1'b0;
      if (frame_pos >= ETH_HDR_LEN) begin
        pay = frame_pos - ETH_HDR_LEN;
        if (cap_etype == ETYPE_IPV4) begin
          hl = 4 * cap_vihl[3:0];
          if (pay >= IP_MIN_HDR && cap_vihl[7:4] == IP_VERSION4 &&
              hl >= IP_MIN_HDR && hl <= pay) begin
            tl = pay - hl;
            addr_ok = 1'b1;
            dec = 1'b1;
            if (cap_proto == PROTO_TCP) begin
              th = 4 * cap_doff[7:4];
              cls = CLS_TCP;
              port_ok = (tl >= TCP_MIN_HDR && th >= TCP_MIN_HDR && th <= tl);
            end else if (cap_proto == PROTO_UDP) begin
              cls = CLS_UDP;
              port_ok = (tl >= UDP_MIN_HDR);
            end else if (cap_proto == PROTO_ICMP) begin
              cls = CLS_ICMP;
            end else begin
              cls = CLS_IPV4;
            end
          end
        end else if (cap_etype == ETYPE_ARP) begin
          cls = CLS_ARP;
          dec = 1'b1;
        end else if (cap_etype == ETYPE_IPV6) begin
          cls = CLS_IPV6;
        end else begin
          cls = CLS_OTHER;
        end
      end
      r = '0;
      r.accepted = (cls != CLS_REJECT);
      r.frame_class = cls;
      r.decoded = dec;
      r.addresses_valid = addr_ok;
      if (addr_ok) begin
        r.source_address = cap_src;
        r.destination_address = cap_dst;
        r.time_to_live = cap_ttl;
      end
      r.ports_valid = port_ok;
      if (port_ok) begin
        r.source_port = cap_sport;
        r.destination_port = cap_dport;
      end
      r.frame_length = POS_W'(frame_pos);
      predicted_results.insert(predicted_results.size(), r);
      // Start the next frame from a clean state
      frame_pos = 0;
      cap_etype = '0;
      cap_vihl = '0;
      cap_proto = '0;
      cap_ttl = '0;
      cap_src = '0;
      cap_dst = '0;
      cap_doff = '0;
      cap_sport = '0;
      cap_dport = '0;
    end
  endtask

  // Send one byte, with an optional idle gap ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_idle_pct) gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    track_byte(b, last);
  endtask

  function automatic void put_byte(input int unsigned pos, input logic [7:0] b);
    if (pos < frame_bytes.size()) frame_bytes[pos] = b;
  endfunction

  // Fill a frame with random bytes, then lay the header fields over it
  task automatic build_frame(input int unsigned len, input logic [15:0] etype,
                             input logic [7:0] vihl, input logic [7:0] ttl,
                             input logic [7:0] proto, input logic [31:0] src,
                             input logic [31:0] dst, input logic [15:0] sport,
                             input logic [15:0] dport, input logic [7:0] doff);
    int unsigned tp;
    frame_bytes.delete();
    repeat (len) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
    tp = 14 + 4 * vihl[3:0];
    put_byte(int'(OFS_ETYPE_HI), etype[15:8]);
    put_byte(int'(OFS_ETYPE_LO), etype[7:0]);
    put_byte(int'(OFS_VER_IHL), vihl);
    put_byte(int'(OFS_TTL), ttl);
    put_byte(int'(OFS_PROTO), proto);
    for (int k = 0; k < 4; k++) begin
      put_byte(int'(OFS_SRC_LO) + k, src[31 - 8 * k -: 8]);
      put_byte(int'(OFS_DST_LO) + k, dst[31 - 8 * k -: 8]);
    end
    put_byte(tp, sport[15:8]);
    put_byte(tp + 1, sport[7:0]);
    put_byte(tp + 2, dport[15:8]);
    put_byte(tp + 3, dport[7:0]);
    put_byte(tp + 12, doff);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frames_sent++;
  endtask

  // IPv4 frame with the given IP payload size and random addresses and ports
  task automatic ipv4_frame(input int unsigned pay, input logic [7:0] vihl,
                            input logic [7:0] proto, input logic [7:0] doff);
    build_frame(14 + pay, ETYPE_IPV4, vihl, 8'($urandom), proto, $urandom, $urandom,
                16'($urandom), 16'($urandom), doff);
    send_frame();
  endtask

  task automatic other_frame(input int unsigned len, input logic [15:0] etype);
    build_frame(len, etype, 8'($urandom), 8'($urandom), 8'($urandom), $urandom,
                $urandom, 16'($urandom), 16'($urandom), 8'($urandom));
    send_frame();
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      class_seen[got.frame_class]++;
      if (got.ports_valid) ports_seen++;
      if (predicted_results.size() == 0) begin
        report_mismatch("result with nothing pending", got[63:0], 64'd0);
      end else begin
        want = predicted_results.pop_front();
        if (got.accepted !== want.accepted)
          report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
        if (got.frame_class !== want.frame_class)
          report_mismatch("frame_class", 64'(got.frame_class), 64'(want.frame_class));
        if (got.decoded !== want.decoded)
          report_mismatch("decoded", 64'(got.decoded), 64'(want.decoded));
        if (got.addresses_valid !== want.addresses_valid)
          report_mismatch("addresses_valid", 64'(got.addresses_valid),
                          64'(want.addresses_valid));
        if (got.source_address !== want.source_address)
          report_mismatch("source_address", 64'(got.source_address),
                          64'(want.source_address));
        if (got.destination_address !== want.destination_address)
          report_mismatch("destination_address", 64'(got.destination_address),
                          64'(want.destination_address));
        if (got.time_to_live !== want.time_to_live)
          report_mismatch("time_to_live", 64'(got.time_to_live), 64'(want.time_to_live));
        if (got.ports_valid !== want.ports_valid)
          report_mismatch("ports_valid", 64'(got.ports_valid), 64'(want.ports_valid));
        if (got.source_port !== want.source_port)
          report_mismatch("source_port", 64'(got.source_port), 64'(want.source_port));
        if (got.destination_port !== want.destination_port)
          report_mismatch("destination_port", 64'(got.destination_port),
                          64'(want.destination_port));
        if (got.frame_length !== want.frame_length)
          report_mismatch("frame_length", 64'(got.frame_length), 64'(want.frame_length));
      end
      result_count++;
    end
    // Stall the result side at random
    if (rx_stall_left > 0) begin
      out_tready <= 1'b0;
      rx_stall_left--;
    end else if ($urandom_range(0, 99) < rx_idle_pct) begin
      rx_stall_left = pick_gap() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Runts, then tiny frames back to back against a slow receiver
  task automatic test_short_frames();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_byte(8'h00, 1'b1);
    frames_sent++;
    send_byte(8'hFF, 1'b1);
    frames_sent++;
    other_frame(13, ETYPE_IPV4);
    rx_idle_pct = 60;
    repeat (12) other_frame($urandom_range(1, 3), 16'($urandom));
  endtask

  task automatic test_ethertypes();
    tx_idle_pct = 25;
    rx_idle_pct = 25;
    other_frame(14, ETYPE_ARP);
    other_frame(14, ETYPE_IPV6);
    other_frame(15, 16'hFFFF);
    other_frame(14, 16'h0801);
    // IPv4 with no payload at all
    other_frame(14, ETYPE_IPV4);
  endtask

  task automatic test_ipv4_header_checks();
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    ipv4_frame(19, 8'h45, PROTO_ICMP, 8'h50);
    // Smallest accepted header, with extremes of TTL and addresses
    build_frame(34, ETYPE_IPV4, 8'h45, 8'h00, PROTO_ICMP, 32'h0, 32'hFFFF_FFFF,
                16'h0, 16'h0, 8'h0);
    send_frame();
    ipv4_frame(20, 8'h65, PROTO_TCP, 8'h50);
    ipv4_frame(20, 8'h44, PROTO_UDP, 8'h50);
    // Header filling the whole payload, then one byte past it
    build_frame(38, ETYPE_IPV4, 8'h46, 8'hFF, 8'h02, 32'hFFFF_FFFF, 32'h0,
                16'h0, 16'h0, 8'h0);
    send_frame();
    ipv4_frame(23, 8'h46, 8'h00, 8'h50);
  endtask

  task automatic test_transport_ports();
    tx_idle_pct = 15;
    rx_idle_pct = 35;
    // Extremes of the ports on frames whose checks pass
    build_frame(54, ETYPE_IPV4, 8'h45, 8'h40, PROTO_TCP, $urandom, $urandom,
                16'h0000, 16'hFFFF, 8'h5F);
    send_frame();
    ipv4_frame(40, 8'h45, PROTO_TCP, 8'h40);
    ipv4_frame(40, 8'h45, PROTO_TCP, 8'h60);
    ipv4_frame(39, 8'h45, PROTO_TCP, 8'h50);
    build_frame(42, ETYPE_IPV4, 8'h45, 8'h40, PROTO_UDP, $urandom, $urandom,
                16'hFFFF, 16'h0000, 8'h00);
    send_frame();
    ipv4_frame(27, 8'h45, PROTO_UDP, 8'h00);
    // Transport header shifted by IPv4 options
    ipv4_frame(48, 8'h47, PROTO_TCP, 8'h50);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_short_frames();
    test_ethertypes();
    test_ipv4_header_checks();
    test_transport_ports();
    in_tvalid <= 1'b0;
    // Drain outstanding results, then watch for strays
    rx_idle_pct = 0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d frames (%0d bytes): runts, each EtherType class, IPv4 version",
             frames_sent, bytes_sent);
    $display("and header length limits, transport port length limits");
    $display("Classes 0..7 seen %0d %0d %0d %0d %0d %0d %0d %0d, ports %0d",
             class_seen[0], class_seen[1], class_seen[2], class_seen[3],
             class_seen[4], class_seen[5], class_seen[6], class_seen[7], ports_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> ethernet_ipv4_header_classifier.f
rtl/eihc_pkg.sv
rtl/ethernet_ipv4_header_classifier.sv
verif/ethernet_ipv4_header_classifier_tb.sv
